// File: rtl/vrbs_pkg.sv
// Shared constants, types and helpers for the variable-length record byte stack.
`timescale 1ns / 1ps

package vrbs_pkg;

    // Store geometry; STACK_BYTES must be a power of two so that addresses wrap.
    localparam int STACK_BYTES  = 256;
    localparam int HEADER_BYTES = 4;
    localparam int MAX_RECORD   = 60;

    localparam int ADDR_W = $clog2(STACK_BYTES);
    localparam int TOP_W  = $clog2(STACK_BYTES + 1);
    localparam int CNT_W  = $clog2(MAX_RECORD + 1);
    localparam int HDR_W  = $clog2(HEADER_BYTES + 1);

    // Request codes carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_LEN_WAIT,
        ST_BYTE_RD,
        ST_BYTE_WAIT,
        ST_RESP
    } state_t;

    // Store port request from the sequencer.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // One result handed to the output register.
    typedef struct packed {
        logic             load;
        status_t          status;
        logic [7:0]       byte_out;
        logic             byte_valid;
        logic             last;
        logic             stack_empty;
        logic [TOP_W-1:0] free_bytes;
    } res_t;

    // Adder results used for addressing and top updates.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TOP_W-1:0]  top_sat;
    } alu_res_t;

    // Lengths above MAX_RECORD are taken as MAX_RECORD.
    function automatic logic [CNT_W-1:0] clamp_len(input logic [7:0] v);
        logic [CNT_W-1:0] r;
        if (v > 8'(MAX_RECORD)) begin
            r = CNT_W'(MAX_RECORD);
        end else begin
            r = v[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/variable_record_byte_stack_top.sv
// Top level of the variable-length record byte stack with its output register.
`timescale 1ns / 1ps

// A stack of byte records of up to 60 bytes in a 256-byte store that grows
// downward; each record sits above a 4-byte header whose low byte is the length.
// The input is taken only while the sequencer is idle. A push body byte and a
// dropped push item go from the accept cycle straight to the response state. The
// first item of an accepted push is followed by one store write per cycle
// through the single write port (four header bytes plus the first data
// byte, or only the header for a zero-length record), then the response state.
// A pop or peek issues the length read in the accept cycle and sees the length
// in the length wait state; each returned byte then passes a read state and a
// wait state, because it goes through the registered read port before it is
// loaded into the output register; when no byte is returned the response state is used.
// Clear and empty answers go from the accept cycle to the response state. A
// result still waiting in the output register stalls the sequencer until
// its transfer completes. Every result carries the free byte count and an
// empty flag as they stand after the whole request.
module variable_record_byte_stack_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // byte_in [7:0], byte_count [13:8], zero [15:14]
    input  logic [15:0] s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status [1:0], byte_out [9:2], stack_empty [10], free_bytes [19:11], zero [23:20]
    output logic [23:0] m_axis_tdata,
    // byte_valid
    output logic        m_axis_tuser,
    // last
    output logic        m_axis_tlast
);
    import vrbs_pkg::*;

    res_t             res;
    ram_req_t         ram_req;
    logic [7:0]       ram_rdata;
    logic [TOP_W-1:0] alu_base;
    logic [TOP_W-1:0] alu_ofs;
    alu_res_t         alu_res;
    logic             out_free;

    logic             m_valid_reg;
    logic [1:0]       status_reg;
    logic [7:0]       byte_out_reg;
    logic             byte_valid_reg;
    logic             last_reg;
    logic             empty_reg;
    logic [TOP_W-1:0] free_reg;

    assign out_free = !m_valid_reg || m_axis_tready;

    vrbs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .req        (req_t'(s_axis_tuser)),
        .byte_in    (s_axis_tdata[7:0]),
        .byte_count (s_axis_tdata[13:8]),
        .out_free   (out_free),
        .res        (res),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .alu_base   (alu_base),
        .alu_ofs    (alu_ofs),
        .alu_res    (alu_res)
    );

    vrbs_alu u_alu (
        .base (alu_base),
        .ofs  (alu_ofs),
        .res  (alu_res)
    );

    vrbs_ram #(
        .WIDTH (8),
        .DEPTH (STACK_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Output valid: set on load, cleared when the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (res.load) begin
            status_reg     <= res.status;
            byte_out_reg   <= res.byte_out;
            byte_valid_reg <= res.byte_valid;
            last_reg       <= res.last;
            empty_reg      <= res.stack_empty;
            free_reg       <= res.free_bytes;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, free_reg, empty_reg, byte_out_reg, status_reg};
    assign m_axis_tuser  = byte_valid_reg;
    assign m_axis_tlast  = last_reg;

`ifndef SYNTHESIS
    // A record byte always comes with an ok status.
    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && byte_valid_reg) |-> (status_reg == STS_OK))
        else $error("record byte delivered with non-ok status");

    // A result without a record byte is the only result of its request.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !byte_valid_reg) |-> last_reg)
        else $error("status-only result without last mark");

    // The empty flag agrees with the free byte count.
    a_empty_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (empty_reg == (free_reg == TOP_W'(STACK_BYTES))))
        else $error("empty flag disagrees with free byte count");

    // The top never rises above the store size.
    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (free_reg <= TOP_W'(STACK_BYTES)))
        else $error("free byte count above store size");
`endif

endmodule

// File: rtl/vrbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vrbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/vrbs_alu.sv
// Shared address adder with wrapped address and saturated top outputs.
`timescale 1ns / 1ps

module vrbs_alu (
    input  logic [vrbs_pkg::TOP_W-1:0] base,
    input  logic [vrbs_pkg::TOP_W-1:0] ofs,
    output vrbs_pkg::alu_res_t         res
);
    import vrbs_pkg::*;

    logic [TOP_W:0] sum;

    // One add serves header writes, byte reads and the new top after a pop.
    assign sum = {1'b0, base} + {1'b0, ofs};

    always_comb begin
        res.addr = sum[ADDR_W-1:0];
        if (sum > (TOP_W+1)'(STACK_BYTES)) begin
            res.top_sat = TOP_W'(STACK_BYTES);
        end else begin
            res.top_sat = sum[TOP_W-1:0];
        end
    end

endmodule

// File: rtl/vrbs_ctrl.sv
// Sequencer and stack state: push commit, header writes and record reads.
`timescale 1ns / 1ps

module vrbs_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  vrbs_pkg::req_t             req,
    input  logic [7:0]                 byte_in,
    input  logic [5:0]                 byte_count,
    input  logic                       out_free,
    output vrbs_pkg::res_t             res,
    output vrbs_pkg::ram_req_t         ram_req,
    input  logic [7:0]                 ram_rdata,
    output logic [vrbs_pkg::TOP_W-1:0] alu_base,
    output logic [vrbs_pkg::TOP_W-1:0] alu_ofs,
    input  vrbs_pkg::alu_res_t         alu_res
);
    import vrbs_pkg::*;

    state_t            state_reg, state_next;
    logic [TOP_W-1:0]  top_reg, top_next;
    logic [TOP_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [7:0]        byte_reg, byte_next;
    logic [HDR_W-1:0]  widx_reg, widx_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              drop_reg, drop_next;
    logic [ADDR_W-1:0] paddr_reg, paddr_next;
    logic [TOP_W-1:0]  pnew_reg, pnew_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic              pop_reg, pop_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    status_t           status_reg, status_next;

    logic [CNT_W-1:0]  len_in;
    logic [TOP_W-1:0]  need;
    logic [CNT_W-1:0]  stored;
    logic [CNT_W-1:0]  n_cnt;
    logic              last_wr;
    logic              last_byte;

    assign in_ready = (state_reg == ST_IDLE);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            top_reg   <= TOP_W'(STACK_BYTES);
            rem_reg   <= '0;
            drop_reg  <= 1'b0;
            paddr_reg <= '0;
            pnew_reg  <= '0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            rem_reg   <= rem_next;
            drop_reg  <= drop_next;
            paddr_reg <= paddr_next;
            pnew_reg  <= pnew_next;
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge aclk) begin
        base_reg   <= base_next;
        len_reg    <= len_next;
        byte_reg   <= byte_next;
        widx_reg   <= widx_next;
        cap_reg    <= cap_next;
        pop_reg    <= pop_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
    end

    // Helpers for the first push item and the length read.
    assign len_in    = clamp_len({2'b00, byte_count});
    assign need      = TOP_W'(len_in) + TOP_W'(HEADER_BYTES);
    assign stored    = clamp_len(ram_rdata);
    assign n_cnt     = (cap_reg < stored) ? cap_reg : stored;
    assign last_wr   = (widx_reg == HDR_W'(HEADER_BYTES)) ||
                       ((len_reg == '0) && (widx_reg == HDR_W'(HEADER_BYTES - 1)));
    assign last_byte = ((idx_reg + CNT_W'(1)) == n_reg);

    // Next state and outputs.
    always_comb begin
        state_next  = state_reg;
        top_next    = top_reg;
        base_next   = base_reg;
        len_next    = len_reg;
        byte_next   = byte_reg;
        widx_next   = widx_reg;
        rem_next    = rem_reg;
        drop_next   = drop_reg;
        paddr_next  = paddr_reg;
        pnew_next   = pnew_reg;
        cap_next    = cap_reg;
        pop_next    = pop_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        status_next = status_reg;

        ram_req     = '0;
        alu_base    = base_reg;
        alu_ofs     = '0;

        res             = '0;
        res.status      = status_reg;
        res.last        = 1'b1;
        res.stack_empty = (top_reg == TOP_W'(STACK_BYTES));
        res.free_bytes  = top_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (req)
                        REQ_PUSH: begin
                            state_next = ST_RESP;
                            if (rem_reg == '0) begin
                                // First item of a record: check space before anything.
                                if (top_reg < need) begin
                                    status_next = STS_FULL;
                                    rem_next    = (len_in != '0) ? len_in - CNT_W'(1) : '0;
                                    drop_next   = (len_in > CNT_W'(1));
                                end else begin
                                    base_next  = top_reg - need;
                                    len_next   = len_in;
                                    byte_next  = byte_in;
                                    widx_next  = '0;
                                    state_next = ST_HDR;
                                end
                            end else if (drop_reg) begin
                                status_next = STS_FULL;
                                rem_next    = rem_reg - CNT_W'(1);
                                if (rem_reg == CNT_W'(1)) begin
                                    drop_next = 1'b0;
                                end
                            end else begin
                                // Body byte of an accepted record.
                                status_next   = STS_OK;
                                ram_req.we    = 1'b1;
                                ram_req.waddr = paddr_reg;
                                ram_req.wdata = byte_in;
                                paddr_next    = paddr_reg + ADDR_W'(1);
                                rem_next      = rem_reg - CNT_W'(1);
                                if (rem_reg == CNT_W'(1)) begin
                                    top_next = pnew_reg;
                                end
                            end
                        end
                        REQ_POP, REQ_PEEK: begin
                            rem_next  = '0;
                            drop_next = 1'b0;
                            if (top_reg >= TOP_W'(STACK_BYTES)) begin
                                status_next = STS_EMPTY;
                                state_next  = ST_RESP;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = top_reg[ADDR_W-1:0];
                                base_next     = top_reg;
                                cap_next      = len_in;
                                pop_next      = (req == REQ_POP);
                                state_next    = ST_LEN_WAIT;
                            end
                        end
                        default: begin
                            rem_next    = '0;
                            drop_next   = 1'b0;
                            top_next    = TOP_W'(STACK_BYTES);
                            status_next = STS_OK;
                            state_next  = ST_RESP;
                        end
                    endcase
                end
            end

            ST_HDR: begin
                // One store write per cycle: length byte, zero bytes, first data byte.
                alu_ofs       = TOP_W'(widx_reg);
                ram_req.we    = 1'b1;
                ram_req.waddr = alu_res.addr;
                if (widx_reg == '0) begin
                    ram_req.wdata = 8'(len_reg);
                end else if (widx_reg == HDR_W'(HEADER_BYTES)) begin
                    ram_req.wdata = byte_reg;
                end else begin
                    ram_req.wdata = 8'd0;
                end
                widx_next = widx_reg + HDR_W'(1);
                if (last_wr) begin
                    status_next = STS_OK;
                    drop_next   = 1'b0;
                    state_next  = ST_RESP;
                    if (len_reg <= CNT_W'(1)) begin
                        top_next = base_reg;
                        rem_next = '0;
                    end else begin
                        rem_next   = len_reg - CNT_W'(1);
                        pnew_next  = base_reg;
                        paddr_next = alu_res.addr + ADDR_W'(1);
                    end
                end
            end

            ST_LEN_WAIT: begin
                // Stored length is back; a pop commits its new top now.
                alu_ofs = TOP_W'(HEADER_BYTES) + TOP_W'(stored);
                if (pop_reg) begin
                    top_next = alu_res.top_sat;
                end
                if (n_cnt == '0) begin
                    status_next = STS_OK;
                    state_next  = ST_RESP;
                end else begin
                    n_next     = n_cnt;
                    idx_next   = '0;
                    state_next = ST_BYTE_RD;
                end
            end

            ST_BYTE_RD: begin
                alu_ofs       = TOP_W'(HEADER_BYTES) + TOP_W'(idx_reg);
                ram_req.re    = 1'b1;
                ram_req.raddr = alu_res.addr;
                state_next    = ST_BYTE_WAIT;
            end

            ST_BYTE_WAIT: begin
                if (out_free) begin
                    res.load       = 1'b1;
                    res.status     = STS_OK;
                    res.byte_out   = ram_rdata;
                    res.byte_valid = 1'b1;
                    res.last       = last_byte;
                    idx_next       = idx_reg + CNT_W'(1);
                    state_next     = last_byte ? ST_IDLE : ST_BYTE_RD;
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    res.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
